// File: rtl/hppj_pkg.sv
// Shared constants and types for the homography projection pipeline.
package hppj_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS = 16;
	localparam int COEF_WIDTH = 21;
	localparam int ROW_WIDTH = 63;
	localparam int CFG_IDX_WIDTH = 3;
	localparam int NUM_QUOT = 11;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_ROW0 = 3'd0,
		REG_ROW1 = 3'd1,
		REG_ROW2 = 3'd2,
		REG_SRC_SCALE = 3'd3,
		REG_TGT_SCALE = 3'd4
	} cfg_reg_t;

endpackage

// File: rtl/hppj_divider.sv
// Pipelined restoring divider: one quotient bit per stage, saturating signed result.
module hppj_divider import hppj_pkg::*; #(
	parameter int NUM_WIDTH = 128,
	parameter int DEN_WIDTH = 96,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int TAG_WIDTH = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [NUM_WIDTH-1:0]   num,
	input  logic signed [DEN_WIDTH-1:0]   den,
	input  logic [TAG_WIDTH-1:0]          tag_in,
	output logic                          out_valid,
	output logic signed [COORD_WIDTH-1:0] quot,
	output logic                          sat,
	output logic [TAG_WIDTH-1:0]          tag_out
);

	// Quotient magnitude above 2^(COORD_WIDTH) always saturates, so only
	// COORD_WIDTH+1 quotient bits are developed; larger ones are flagged early.
	localparam int QB = COORD_WIDTH + 1;
	localparam int NUM_STAGES = QB;
	localparam int RW = DEN_WIDTH + 1;

	logic                 v_s [NUM_STAGES+1];
	logic [NUM_WIDTH-1:0] n_s [NUM_STAGES+1];
	logic [DEN_WIDTH-1:0] d_s [NUM_STAGES+1];
	logic [RW-1:0]        r_s [NUM_STAGES+1];
	logic [QB-1:0]        q_s [NUM_STAGES+1];
	logic                 ng_s [NUM_STAGES+1];
	logic                 big_s [NUM_STAGES+1];
	logic                 nz_s [NUM_STAGES+1];
	logic                 dz_s [NUM_STAGES+1];
	logic [TAG_WIDTH-1:0] t_s [NUM_STAGES+1];

	logic [NUM_WIDTH-1:0] num_abs;
	logic [DEN_WIDTH-1:0] den_abs;
	logic                 hi_big;

	always_comb begin
		num_abs = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
		den_abs = den[DEN_WIDTH-1] ? DEN_WIDTH'(-den) : DEN_WIDTH'(den);
		// num >= den << QB means quotient >= 2^QB.
		hi_big = ({{QB{1'b0}}, num_abs} >=
			({{(NUM_WIDTH+QB-DEN_WIDTH){1'b0}}, den_abs} << QB))
			&& (den_abs != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0] <= num_abs;
			d_s[0] <= den_abs;
			r_s[0] <= RW'((num_abs >> QB));
			q_s[0] <= '0;
			ng_s[0] <= num[NUM_WIDTH-1] ^ den[DEN_WIDTH-1];
			big_s[0] <= hi_big;
			nz_s[0] <= (num != '0);
			dz_s[0] <= (den == '0);
			t_s[0] <= tag_in;
		end
	end

	for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
		logic [RW-1:0] sh;
		logic [RW:0]   df;
		always_comb begin
			sh = {r_s[k][RW-2:0], n_s[k][QB-1-k]};
			df = {1'b0, sh} - {2'b00, d_s[k]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1] <= n_s[k];
				d_s[k+1] <= d_s[k];
				r_s[k+1] <= df[RW] ? sh : df[RW-1:0];
				q_s[k+1] <= {q_s[k][QB-2:0], ~df[RW]};
				ng_s[k+1] <= ng_s[k];
				big_s[k+1] <= big_s[k];
				nz_s[k+1] <= nz_s[k];
				dz_s[k+1] <= dz_s[k];
				t_s[k+1] <= t_s[k];
			end
		end
	end

	localparam logic [QB-1:0] MAXP = {2'b00, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [QB-1:0] MAXN = {2'b01, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [COORD_WIDTH-1:0] VMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] VMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic [QB-1:0] qf;
	logic          neg;
	always_comb begin
		qf = q_s[NUM_STAGES];
		neg = ng_s[NUM_STAGES];
		out_valid = v_s[NUM_STAGES];
		tag_out = t_s[NUM_STAGES];
		sat = 1'b0;
		if (dz_s[NUM_STAGES]) begin
			sat = 1'b1;
			quot = !nz_s[NUM_STAGES] ? '0 : (neg ? VMIN : VMAX);
		end else if (big_s[NUM_STAGES] || (neg ? (qf > MAXN) : (qf > MAXP))) begin
			sat = 1'b1;
			quot = neg ? VMIN : VMAX;
		end else begin
			quot = neg ? COORD_WIDTH'(-qf) : COORD_WIDTH'(qf);
		end
	end

endmodule

// File: rtl/homography_point_projection_jacobian_top.sv
// Top level: homography projection of one point with its Jacobian terms.
//  channel | direction | fields (lowest bit up)
//  s_axis  | in        | src_x, src_y
//  m_axis  | out       | dst_x, dst_y, nine Jacobian terms, error_flag (tuser)
//  cfg     | in        | row coefficient and scale registers
// One point enters per cycle while the output is not stalled. Two bit-per-stage
// divider pipelines run in series (projection, then Jacobian terms). Reset clears
// valid bits and row registers, sets both scales to 1.0. A stall freezes the whole
// pipeline; the output register is the only point of contact with the consumer.
module homography_point_projection_jacobian_top import hppj_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0]     cfg_idx,
	input  logic [((ROW_WIDTH > COORD_WIDTH) ? ROW_WIDTH : COORD_WIDTH)-1:0] cfg_data,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// src_x, src_y
	input  logic [2*COORD_WIDTH-1:0]     s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// dst_x, dst_y, jac_x, jac_y, jac_w, jac_xx, jac_yx, jac_wx, jac_xy, jac_yy, jac_wy
	output logic [11*COORD_WIDTH-1:0]    m_axis_tdata,
	// error_flag
	output logic                         m_axis_tuser
);

	localparam int CW = COORD_WIDTH;
	localparam int PW = COEF_WIDTH + CW + 2;
	localparam int NW = PW + CW + FRAC_BITS + 2;
	localparam int TW = 3 * CW + PW;
	localparam int LW = PW / 2;
	localparam int HW = PW - LW;

	logic [ROW_WIDTH-1:0] row_q [3];
	logic signed [CW-1:0] ss_q, ts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= '0;
			row_q[1] <= '0;
			row_q[2] <= '0;
			ss_q <= CW'(1 << FRAC_BITS);
			ts_q <= CW'(1 << FRAC_BITS);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ROW0: row_q[0] <= cfg_data[ROW_WIDTH-1:0];
				REG_ROW1: row_q[1] <= cfg_data[ROW_WIDTH-1:0];
				REG_ROW2: row_q[2] <= cfg_data[ROW_WIDTH-1:0];
				REG_SRC_SCALE: ss_q <= cfg_data[CW-1:0];
				REG_TGT_SCALE: ts_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic out_v_q;
	logic v_s1, v_s2, v_s3, v_s4;
	assign en = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: nine coefficient products.
	logic signed [CW-1:0] sx_s1, sy_s1;
	logic signed [COEF_WIDTH+CW-1:0] pr_s1 [3][3];
	logic signed [CW-1:0] vin [3];
	assign vin[0] = s_axis_tdata[CW-1:0];
	assign vin[1] = s_axis_tdata[2*CW-1:CW];
	assign vin[2] = ss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			always_ff @(posedge clk) begin
				if (en) begin
					pr_s1[r][c] <= $signed(row_q[r][COEF_WIDTH*c +: COEF_WIDTH]) * vin[c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= vin[0];
			sy_s1 <= vin[1];
		end
	end

	// Stage 2: row sums.
	logic signed [PW-1:0] p_s2 [3];
	logic signed [CW-1:0] sx_s2, sy_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				p_s2[r] <= PW'(pr_s1[r][0]) + PW'(pr_s1[r][1]) + PW'(pr_s1[r][2]);
			end
			sx_s2 <= sx_s1;
			sy_s2 <= sy_s1;
		end
	end

	// Stage 3: partial products of the first numerators with the target scale.
	// The row sums are split in a low and a high half to keep each multiplier narrow.
	logic signed [LW+CW:0]    pl_s3 [2];
	logic signed [HW+CW-1:0]  ph_s3 [2];
	logic signed [2*CW-1:0]   st_s3 [3];
	logic signed [PW-1:0]     p2_s3;
	logic signed [CW-1:0]     sx_s3, sy_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 2; r++) begin
				pl_s3[r] <= $signed({1'b0, p_s2[r][LW-1:0]}) * ts_q;
				ph_s3[r] <= $signed(p_s2[r][PW-1:LW]) * ts_q;
			end
			st_s3[0] <= sx_s2 * ts_q;
			st_s3[1] <= sy_s2 * ts_q;
			st_s3[2] <= ss_q * ts_q;
			p2_s3 <= p_s2[2];
			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;
		end
	end

	// Stage 4: numerators for the first divider set.
	logic signed [NW-1:0] n_s4 [5];
	logic signed [PW-1:0] p2_s4;
	logic signed [CW-1:0] sx_s4, sy_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 2; r++) begin
				n_s4[r] <= (NW'(ph_s3[r]) <<< LW) + NW'(pl_s3[r]);
			end
			for (int i = 0; i < 3; i++) begin
				n_s4[i + 2] <= NW'(st_s3[i]) <<< FRAC_BITS;
			end
			p2_s4 <= p2_s3;
			sx_s4 <= sx_s3;
			sy_s4 <= sy_s3;
		end
	end

	logic [TW-1:0] tag4;
	assign tag4 = {p2_s4, sx_s4, sy_s4, ss_q};

	logic signed [CW-1:0] qa [5];
	logic                 sa [5];
	logic                 va [5];
	logic [TW-1:0]        ta [5];
	for (genvar i = 0; i < 5; i++) begin : g_diva
		hppj_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(PW), .COORD_WIDTH(CW),
			.TAG_WIDTH(TW)) u_div (
			.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
			.num(n_s4[i]), .den(p2_s4), .tag_in(tag4),
			.out_valid(va[i]), .quot(qa[i]), .sat(sa[i]), .tag_out(ta[i]));
	end

	logic signed [PW-1:0] p2a;
	logic signed [CW-1:0] sxa, sya, ssa;
	assign {p2a, sxa, sya, ssa} = ta[0];

	logic signed [2*CW-1:0] jp [6];
	assign jp[0] = sxa * qa[0];
	assign jp[1] = sya * qa[0];
	assign jp[2] = ssa * qa[0];
	assign jp[3] = sxa * qa[1];
	assign jp[4] = sya * qa[1];
	assign jp[5] = ssa * qa[1];

	// Stage 5: Jacobian numerators -v*dst*2^16.
	logic signed [NW-1:0] n_s5 [6];
	logic signed [PW-1:0] p2_s5;
	logic signed [CW-1:0] r_s5 [5];
	logic                 e_s5, v_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= va[0];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) n_s5[i] <= -(NW'(jp[i]) <<< FRAC_BITS);
			p2_s5 <= p2a;
			for (int i = 0; i < 5; i++) r_s5[i] <= qa[i];
			e_s5 <= sa[0] | sa[1] | sa[2] | sa[3] | sa[4];
		end
	end

	localparam int T2 = 5 * CW + 1;
	logic [T2-1:0] tag5;
	assign tag5 = {r_s5[4], r_s5[3], r_s5[2], r_s5[1], r_s5[0], e_s5};

	logic signed [CW-1:0] qb [6];
	logic                 sb [6];
	logic                 vb [6];
	logic [T2-1:0]        tb [6];
	for (genvar i = 0; i < 6; i++) begin : g_divb
		hppj_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(PW), .COORD_WIDTH(CW),
			.TAG_WIDTH(T2)) u_div (
			.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5),
			.num(n_s5[i]), .den(p2_s5), .tag_in(tag5),
			.out_valid(vb[i]), .quot(qb[i]), .sat(sb[i]), .tag_out(tb[i]));
	end

	logic [11*CW-1:0] data_q;
	logic             err_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= vb[0];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= {qb[5], qb[4], qb[3], qb[2], qb[1], qb[0], tb[0][T2-1:1]};
			err_q <= tb[0][0] | sb[0] | sb[1] | sb[2] | sb[3] | sb[4] | sb[5];
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = data_q;
	assign m_axis_tuser = err_q;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output empty");
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		va[0] == va[4] && vb[0] == vb[5])
		else $error("divider lanes out of step");

endmodule
